[sv/bda_pkg.sv]
`timescale 1ns / 1ps

package bda_pkg;

   // fixed widths of the debounce core
   localparam int HIST_W        = 8;
   localparam int COUNT_W       = 4;
   localparam int TIME_W        = 32;
   localparam int WINDOW_W      = 21;
   localparam int TIMEOUT_W     = 8;
   localparam int WINDOW_STEP_MS = 5000;

   // request kind carried in tuser
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_WAKE = 1'b1
   } bda_op_type;

   // per-button findings handed to the merge stage
   typedef struct packed {
      logic fired;
      logic latched;
      logic active;
   } bda_lane_out_type;

   // number of set bits in a history byte
   function automatic logic [COUNT_W-1:0] ones_in(input logic [HIST_W-1:0] v);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < HIST_W; k++) begin
         n = n + COUNT_W'(v[k]);
      end
      return n;
   endfunction

endpackage

[sv/bda_lane.sv]
`timescale 1ns / 1ps

module bda_lane
   import bda_pkg::*;
#(
   parameter int PRESS_THRESHOLD   = 4,
   parameter int RELEASE_THRESHOLD = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  wake,
   input  logic                  pressed,
   input  logic                  accepts,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [WINDOW_W-1:0]   window,
   output bda_lane_out_type      lane_out
);

   logic [HIST_W-1:0]  hist_ff, hist_in;
   logic               rec_ff, rec_in;
   logic               done_ff, done_in;
   logic [TIME_W-1:0]  pt_ff, pt_in;
   logic [HIST_W-1:0]  h_shift;
   logic [COUNT_W-1:0] ones;
   logic               fired;
   logic [TIME_W-1:0]  age;

   assign h_shift = {hist_ff[HIST_W-2:0], pressed};
   assign ones    = ones_in(h_shift);

   // debounce and one-shot flag update
   always_comb begin
      hist_in = h_shift;
      rec_in  = rec_ff;
      done_in = done_ff;
      pt_in   = pt_ff;
      fired   = 1'b0;
      if (wake) begin
         hist_in = HIST_W'(PRESS_THRESHOLD);
         rec_in  = 1'b1;
         done_in = 1'b1;
         pt_in   = now_ms;
      end else if (pressed) begin
         if (ones >= COUNT_W'(PRESS_THRESHOLD)) begin
            if (!rec_ff) begin
               pt_in  = now_ms;
               rec_in = 1'b1;
            end
            if (!done_ff && accepts) begin
               done_in = 1'b1;
               fired   = 1'b1;
            end
         end
      end else if (ones <= COUNT_W'(RELEASE_THRESHOLD)) begin
         rec_in  = 1'b0;
         done_in = 1'b0;
      end
   end

   // activity against the updated press time
   assign age              = now_ms - pt_in;
   assign lane_out.fired   = fired;
   assign lane_out.latched = rec_in;
   assign lane_out.active  = age < TIME_W'(window);

   // per-button state
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         rec_ff  <= 1'b0;
         done_ff <= 1'b0;
         pt_ff   <= '0;
      end else if (en) begin
         hist_ff <= hist_in;
         rec_ff  <= rec_in;
         done_ff <= done_in;
         pt_ff   <= pt_in;
      end
   end

endmodule

[sv/bda_merge.sv]
`timescale 1ns / 1ps

module bda_merge
   import bda_pkg::*;
#(
   parameter int NUM_BUTTONS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_accept,
   input  logic                     window_zero,
   input  bda_lane_out_type         lane_res [NUM_BUTTONS],
   output logic                     ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((2*NUM_BUTTONS+1+7)/8)*8-1:0] rsp_tdata
);

   localparam int RSP_W = ((2*NUM_BUTTONS+1+7)/8)*8;

   logic [NUM_BUTTONS-1:0] fired_v;
   logic [NUM_BUTTONS-1:0] latched_v;
   logic [NUM_BUTTONS-1:0] active_v;
   logic                   active;
   logic                   valid_ff, valid_in;
   logic [RSP_W-1:0]       data_ff;

   // gather lane bits and combine activity
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         fired_v[i]   = lane_res[i].fired;
         latched_v[i] = lane_res[i].latched;
         active_v[i]  = lane_res[i].active;
      end
   end

   assign active = window_zero || (|active_v);

   // output register, refilled while the old request drains
   assign ready    = !valid_ff || rsp_tready;
   assign valid_in = in_accept || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         data_ff <= RSP_W'({active, latched_v, fired_v});
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[sv/button_debounce_activity.sv]
`timescale 1ns / 1ps
// channel   direction  ports                              contents (lowest bit up)
// req       in         req_tvalid/tready/tdata/tuser      raw_pressed, handler_accepts, now_ms
// rsp       out        rsp_tvalid/tready/tdata            fired, press_latched, active
// csr       in         csr_wen/csr_wdata                  sleep_timeout
//
// one request per cycle unless a held result meets a low rsp_tready; each button lane updates
// its state in the accept cycle and the result sits in the output register on the next cycle.
// the window register is loaded from a small multiply on every csr write.
// reset is synchronous and clears all button state, the window and rsp_tvalid.
// req_tready drops only while a result is held and rsp_tready is low.

module button_debounce_activity
   import bda_pkg::*;
#(
   parameter int NUM_BUTTONS       = 3,
   parameter int PRESS_THRESHOLD   = 4,
   parameter int RELEASE_THRESHOLD = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // raw_pressed, handler_accepts, now_ms, zero fill
   input  logic [((2*NUM_BUTTONS+TIME_W+7)/8)*8-1:0] req_tdata,
   // op
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // fired, press_latched, active, zero fill
   output logic [((2*NUM_BUTTONS+1+7)/8)*8-1:0] rsp_tdata,
   input  logic                     csr_wen,
   input  logic [TIMEOUT_W-1:0]     csr_wdata
);

   localparam int NOW_LO = 2*NUM_BUTTONS;

   logic                   accept;
   logic                   wake;
   logic [NUM_BUTTONS-1:0] raw_pressed;
   logic [NUM_BUTTONS-1:0] handler_accepts;
   logic [TIME_W-1:0]      now_ms;
   logic [WINDOW_W-1:0]    window_ff;
   bda_lane_out_type       lane_res [NUM_BUTTONS];

   // request unpacking
   assign accept          = req_tvalid && req_tready;
   assign wake            = bda_op_type'(req_tuser) == OP_WAKE;
   assign raw_pressed     = req_tdata[NUM_BUTTONS-1:0];
   assign handler_accepts = req_tdata[2*NUM_BUTTONS-1:NUM_BUTTONS];
   assign now_ms          = req_tdata[NOW_LO+TIME_W-1:NOW_LO];

   // activity window in ms
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (csr_wen) begin
         window_ff <= WINDOW_W'(csr_wdata) * WINDOW_W'(WINDOW_STEP_MS);
      end
   end

   // one lane per button
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      bda_lane #(
         .PRESS_THRESHOLD   (PRESS_THRESHOLD),
         .RELEASE_THRESHOLD (RELEASE_THRESHOLD)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (accept),
         .wake     (wake),
         .pressed  (raw_pressed[g]),
         .accepts  (handler_accepts[g]),
         .now_ms   (now_ms),
         .window   (window_ff),
         .lane_out (lane_res[g])
      );
   end

   // merge and output register
   bda_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (accept),
      .window_zero (window_ff == '0),
      .lane_res    (lane_res),
      .ready       (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
